@@ sv/gwwf_pkg.sv @@
package gwwf_pkg;

    localparam int MAX_WIDTH_DEF  = 16;
    localparam int MAX_FRAMES_DEF = 256;
    localparam int CFG_W          = 5;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST = 5'd16;
    localparam logic             REG_FRAME_WIDTH = 1'b0;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;

    typedef enum logic [3:0] {
        S_IDLE,
        S_W_CHK,
        S_W_SPLIT,
        S_W_SHIFT,
        S_W_APPEND,
        S_C_CHK,
        S_C_SPACE,
        S_C_COPY,
        S_FINAL,
        S_CLEAR,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_EMIT,
        OP_SHIFT,
        OP_APPEND,
        OP_SPACE,
        OP_COPY,
        OP_CLEAR
    } t_op;

    typedef enum logic [1:0] {
        SRC_LINE,
        SRC_WORD,
        SRC_BLANK
    } t_src;

    typedef struct packed {
        t_op  op;
        t_src src;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic in_word;
        logic in_sep;
        logic in_end;
        logic end_flag;
        logic wl_zero;
        logic wl_ge_w;
        logic ll_zero;
        logic need_big;
        logic saw_word;
        logic emit_done;
        logic shift_done;
        logic copy_done;
    } t_status;

endpackage

@@ sv/gwwf_ctrl.sv @@
module gwwf_ctrl
    import gwwf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    t_src   r_src, n_src;
    logic   r_last, n_last;
    logic   r_in_end, n_in_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_src    <= SRC_LINE;
            r_last   <= 1'b0;
            r_in_end <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_src    <= n_src;
            r_last   <= n_last;
            r_in_end <= n_in_end;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_src    = r_src;
        n_last   = r_last;
        n_in_end = r_in_end;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in_end = 1'b0;
                    if (i_status.in_word) begin
                        n_state = i_status.wl_ge_w ? S_W_CHK : S_W_APPEND;
                    end else if (i_status.in_sep) begin
                        n_state = S_C_CHK;
                    end else if (i_status.in_end) begin
                        n_in_end = 1'b1;
                        n_state  = S_C_CHK;
                    end
                end
            end
            S_W_CHK: begin
                if (!i_status.ll_zero) begin
                    n_state = S_EMIT;
                    n_src   = SRC_LINE;
                    n_last  = 1'b0;
                    n_ret   = S_W_SPLIT;
                end else begin
                    n_state = S_W_SPLIT;
                end
            end
            S_W_SPLIT: begin
                if (i_status.wl_ge_w) begin
                    n_state = S_EMIT;
                    n_src   = SRC_WORD;
                    n_last  = 1'b0;
                    n_ret   = S_W_SHIFT;
                end else begin
                    n_state = S_W_APPEND;
                end
            end
            S_W_SHIFT: begin
                if (i_status.shift_done) begin
                    n_state = S_W_SPLIT;
                end
            end
            S_W_APPEND: begin
                if (i_status.end_flag) begin
                    n_in_end = 1'b1;
                    n_state  = S_C_CHK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_C_CHK: begin
                if (i_status.wl_zero) begin
                    if (r_in_end) begin
                        n_state = S_FINAL;
                    end else if (i_status.end_flag) begin
                        n_in_end = 1'b1;
                        n_state  = S_C_CHK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (i_status.need_big && !i_status.ll_zero) begin
                    n_state = S_EMIT;
                    n_src   = SRC_LINE;
                    n_last  = 1'b0;
                    n_ret   = S_C_SPACE;
                end else begin
                    n_state = S_C_SPACE;
                end
            end
            S_C_SPACE: begin
                n_state = S_C_COPY;
            end
            S_C_COPY: begin
                if (i_status.copy_done) begin
                    if (r_in_end) begin
                        n_state = S_FINAL;
                    end else if (i_status.end_flag) begin
                        n_in_end = 1'b1;
                        n_state  = S_C_CHK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FINAL: begin
                if (!i_status.ll_zero) begin
                    n_state = S_EMIT;
                    n_src   = SRC_LINE;
                    n_last  = 1'b1;
                    n_ret   = S_CLEAR;
                end else if (!i_status.saw_word) begin
                    n_state = S_EMIT;
                    n_src   = SRC_BLANK;
                    n_last  = 1'b1;
                    n_ret   = S_CLEAR;
                end else begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                n_state = S_IDLE;
            end
            S_EMIT: begin
                if (i_status.emit_done) begin
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NONE;
        o_cmd.src  = r_src;
        o_cmd.last = r_last;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                end
            end
            S_W_SHIFT:  o_cmd.op = OP_SHIFT;
            S_W_APPEND: o_cmd.op = OP_APPEND;
            S_C_SPACE: begin
                if (!i_status.ll_zero) begin
                    o_cmd.op = OP_SPACE;
                end
            end
            S_C_COPY:   o_cmd.op = OP_COPY;
            S_CLEAR:    o_cmd.op = OP_CLEAR;
            S_EMIT:     o_cmd.op = OP_EMIT;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

endmodule

@@ sv/gwwf_datapath.sv @@
module gwwf_datapath
    import gwwf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    input  logic [7:0]       i_in_char,
    input  logic             i_has_char,
    input  logic             i_message_end,
    input  logic [CFG_W-1:0] i_frame_width,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_frame_char,
    output logic             o_end_of_frame,
    output logic             o_end_of_message
);

    localparam int LW = $clog2(MAX_WIDTH + 1);
    localparam int IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int FW = $clog2(MAX_FRAMES + 1);

    logic [7:0]    r_line [MAX_WIDTH];
    logic [7:0]    r_word [MAX_WIDTH];
    logic [LW-1:0] r_ll;
    logic [LW-1:0] r_wl;
    logic [LW-1:0] r_k;
    logic          r_saw;
    logic [FW-1:0] r_frames;
    logic [7:0]    r_char;
    logic          r_end;
    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic          r_out_eof;
    logic          r_out_eom;

    logic [LW-1:0] w;
    logic          in_sep;
    logic [LW+1:0] need;
    logic [LW:0]   kw;
    logic          k_last;
    logic          slot_free;
    logic          skip;
    logic          emit_load;
    logic          emit_done;
    logic          shift_done;
    logic          copy_done;
    logic [IW-1:0] word_addr;
    logic [7:0]    word_rd;
    logic [7:0]    line_rd;
    logic [7:0]    emit_char;
    logic          emit_eom;

    always_comb begin
        if (i_frame_width == '0) begin
            w = LW'(1);
        end else if (i_frame_width > CFG_W'(MAX_WIDTH)) begin
            w = LW'(MAX_WIDTH);
        end else begin
            w = LW'(i_frame_width);
        end
    end

    assign in_sep = (i_in_char == CHAR_SPACE) || (i_in_char == CHAR_TAB) ||
                    (i_in_char == CHAR_LF) || (i_in_char == CHAR_CR);

    assign need = (r_ll == '0) ? (LW+2)'(r_wl)
                               : (LW+2)'(r_ll) + (LW+2)'(r_wl) + (LW+2)'(1);
    assign kw   = (LW+1)'(r_k) + (LW+1)'(w);

    assign k_last     = (r_k == w - LW'(1));
    assign slot_free  = !r_out_valid || i_out_ready;
    assign skip       = (r_frames == FW'(MAX_FRAMES));
    assign emit_load  = (i_cmd.op == OP_EMIT) && !skip && slot_free;
    assign emit_done  = skip || (slot_free && k_last);
    assign shift_done = (kw >= (LW+1)'(r_wl));
    assign copy_done  = (r_k >= r_wl);

    assign word_addr = (i_cmd.op == OP_SHIFT) ? kw[IW-1:0] : r_k[IW-1:0];
    assign word_rd   = r_word[word_addr];
    assign line_rd   = r_line[r_k[IW-1:0]];

    always_comb begin
        case (i_cmd.src)
            SRC_LINE:  emit_char = (r_k < r_ll) ? line_rd : CHAR_SPACE;
            SRC_WORD:  emit_char = word_rd;
            default:   emit_char = CHAR_SPACE;
        endcase
    end

    // last result of an end item: the closing frame, or the frame that hits the limit
    assign emit_eom = k_last && r_end &&
                      (i_cmd.last || (r_frames == FW'(MAX_FRAMES - 1)));

    always_comb begin
        o_status.in_word    = i_has_char && !in_sep;
        o_status.in_sep     = i_has_char && in_sep;
        o_status.in_end     = i_message_end;
        o_status.end_flag   = r_end;
        o_status.wl_zero    = (r_wl == '0);
        o_status.wl_ge_w    = (r_wl >= w);
        o_status.ll_zero    = (r_ll == '0);
        o_status.need_big   = (need > (LW+2)'(w));
        o_status.saw_word   = r_saw;
        o_status.emit_done  = emit_done;
        o_status.shift_done = shift_done;
        o_status.copy_done  = copy_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ll     <= '0;
            r_wl     <= '0;
            r_k      <= '0;
            r_saw    <= 1'b0;
            r_frames <= '0;
            r_end    <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_end <= i_message_end;
                end
                OP_EMIT: begin
                    if (emit_load) begin
                        if (k_last) begin
                            r_k      <= '0;
                            r_frames <= r_frames + FW'(1);
                        end else begin
                            r_k <= r_k + LW'(1);
                        end
                    end
                    if (emit_done && (i_cmd.src == SRC_LINE)) begin
                        r_ll <= '0;
                    end
                end
                OP_SHIFT: begin
                    if (shift_done) begin
                        r_wl <= r_wl - w;
                        r_k  <= '0;
                    end else begin
                        r_k <= r_k + LW'(1);
                    end
                end
                OP_APPEND: begin
                    if (r_wl < LW'(MAX_WIDTH)) begin
                        r_wl <= r_wl + LW'(1);
                    end
                    r_saw <= 1'b1;
                end
                OP_SPACE: begin
                    r_ll <= r_ll + LW'(1);
                end
                OP_COPY: begin
                    if (copy_done) begin
                        r_wl <= '0;
                        r_k  <= '0;
                    end else begin
                        r_ll <= r_ll + LW'(1);
                        r_k  <= r_k + LW'(1);
                    end
                end
                OP_CLEAR: begin
                    r_ll     <= '0;
                    r_wl     <= '0;
                    r_saw    <= 1'b0;
                    r_frames <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_char <= i_in_char;
        end
        if ((i_cmd.op == OP_SHIFT) && !shift_done) begin
            r_word[r_k[IW-1:0]] <= word_rd;
        end
        if ((i_cmd.op == OP_APPEND) && (r_wl < LW'(MAX_WIDTH))) begin
            r_word[r_wl[IW-1:0]] <= r_char;
        end
        if (i_cmd.op == OP_SPACE) begin
            r_line[r_ll[IW-1:0]] <= CHAR_SPACE;
        end
        if ((i_cmd.op == OP_COPY) && !copy_done) begin
            r_line[r_ll[IW-1:0]] <= word_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out_char <= emit_char;
            r_out_eof  <= k_last;
            r_out_eom  <= emit_eom;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame_char     = r_out_char;
    assign o_end_of_frame   = r_out_eof;
    assign o_end_of_message = r_out_eom;

endmodule

@@ sv/greedy_word_wrap_framer_unit.sv @@
// a word character is transferred, then stored in the word buffer; a full word
// first sends the open line, then frames of the word, shifting the rest down;
// a separator moves the word into the line, after a space if the line is open;
// a message end sends the last line, or a blank frame if no word came; frames go
// via the output register one character per cycle; an output stall holds the input
// reset: synchronous active low; clears all but buffers, held char and output data
module greedy_word_wrap_framer_unit
    import gwwf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_in_char,
    input  logic              i_has_char,
    input  logic              i_message_end,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_frame_char,
    output logic              o_end_of_frame,
    output logic              o_end_of_message
);

    logic [CFG_W-1:0] r_frame_width;
    t_cmd             cmd;
    t_status          status;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= FRAME_WIDTH_RST;
        end else if (psel && penable && pwrite && (paddr[2] == REG_FRAME_WIDTH)) begin
            r_frame_width <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_FRAME_WIDTH) ?
                    {{(APB_DW-CFG_W){1'b0}}, r_frame_width} : '0;

    gwwf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gwwf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_in_char        (i_in_char),
        .i_has_char       (i_has_char),
        .i_message_end    (i_message_end),
        .i_frame_width    (r_frame_width),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_frame_char     (o_frame_char),
        .o_end_of_frame   (o_end_of_frame),
        .o_end_of_message (o_end_of_message)
    );

endmodule

@@ sv/gwwf_checker.sv @@
module gwwf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_has_char,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_frame_char,
    input logic       o_end_of_frame,
    input logic       o_end_of_message
);

    // message end mark only on the closing character of a frame
    a_eom_on_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_message) |-> o_end_of_frame)
        else $error("end_of_message without end_of_frame");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a character transfer always keeps the sequencer busy for the next cycle
    a_char_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_has_char) |=> !o_in_ready)
        else $error("input ready right after a character transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_frame_char) && $stable(o_end_of_frame)))
        else $error("stalled output changed");

endmodule

bind greedy_word_wrap_framer_unit gwwf_checker u_gwwf_checker (.*);

@@ tb/sv/greedy_word_wrap_framer_unit_test.sv @@
`timescale 1ns / 1ps

module greedy_word_wrap_framer_unit_test;
    import gwwf_pkg::*;

    localparam int RESULTS_PER_STEP = 48;
    localparam int RANDOM_ITEMS     = 430;
    localparam int LONG_RUN         = 258;
    localparam int SETTLE_CYCLES    = 64;
    localparam int HOLD_CYCLES      = 300;
    localparam int STALL_LIMIT      = 3000;
    localparam int MAX_REPORTS      = 40;
    localparam int N_PHASES         = 9;
    localparam logic [APB_AW-1:0] ADDR_FRAME_WIDTH = APB_AW'(4 * int'(REG_FRAME_WIDTH));

    typedef struct {
        logic [7:0] ch;
        logic       has;
        logic       fin;
        int         gap;
    } t_text_item;

    typedef struct packed {
        logic [7:0] ch;
        logic       eof;
        logic       eom;
    } t_frame_beat;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [7:0]        i_in_char = 8'h00;
    logic              i_has_char = 1'b0;
    logic              i_message_end = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [7:0]        o_frame_char;
    logic              o_end_of_frame;
    logic              o_end_of_message;

    greedy_word_wrap_framer_unit dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // wrap state mirrored from the block
    logic [7:0]       line_buf [MAX_WIDTH_DEF];
    logic [7:0]       word_buf [MAX_WIDTH_DEF];
    int               line_len = 0;
    int               word_len = 0;
    int               frame_count = 0;
    int               step_beats = 0;
    bit               seen_text = 1'b0;
    logic [CFG_W-1:0] frame_width_q = FRAME_WIDTH_RST;

    t_frame_beat exp_frame_beats [$];
    t_text_item  text_q [$];
    int          err_cnt = 0;
    int          stim_cnt = 0;
    int          beat_cnt = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;

    function automatic bit is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR;
    endfunction

    function automatic int eff_width();
        if (frame_width_q == 0) return 1;
        if (frame_width_q > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return int'(frame_width_q);
    endfunction

    function automatic void emit_frame(input bit from_word, input int len, input int w);
        logic [7:0] c;
        if (frame_count >= MAX_FRAMES_DEF) return;
        if (step_beats + w > RESULTS_PER_STEP) return;
        for (int i = 0; i < w; i++) begin
            if (i < len && i < MAX_WIDTH_DEF) c = from_word ? word_buf[i] : line_buf[i];
            else c = CHAR_SPACE;
            exp_frame_beats.insert(exp_frame_beats.size(),
                                   '{ch: c, eof: (i == w - 1), eom: 1'b0});
            step_beats++;
        end
        frame_count++;
    endfunction

    function automatic void send_line(input int w);
        if (line_len > 0) emit_frame(1'b0, line_len, w);
        line_len = 0;
    endfunction

    function automatic void place_word(input int w);
        int need;
        if (word_len == 0) return;
        need = (line_len > 0) ? line_len + 1 + word_len : word_len;
        if (need > w || need > MAX_WIDTH_DEF) send_line(w);
        if (line_len > 0) begin
            line_buf[line_len] = CHAR_SPACE;
            line_len++;
        end
        for (int i = 0; i < word_len; i++) line_buf[line_len + i] = word_buf[i];
        line_len += word_len;
        word_len = 0;
    endfunction

    function automatic void add_letter(input logic [7:0] c, input int w);
        if (word_len >= w) begin
            send_line(w);
            while (word_len >= w) begin
                emit_frame(1'b1, w, w);
                for (int i = 0; i < word_len - w; i++) word_buf[i] = word_buf[i + w];
                word_len -= w;
            end
        end
        if (word_len < MAX_WIDTH_DEF) begin
            word_buf[word_len] = c;
            word_len++;
        end
        seen_text = 1'b1;
    endfunction

    function automatic void wrap_step(input logic [7:0] c, input logic has, input logic fin);
        int w;
        w = eff_width();
        step_beats = 0;
        if (has) begin
            if (is_blank(c)) place_word(w);
            else add_letter(c, w);
        end
        if (fin) begin
            place_word(w);
            if (line_len > 0) send_line(w);
            else if (!seen_text) emit_frame(1'b0, 0, w);
            if (step_beats > 0) exp_frame_beats[exp_frame_beats.size() - 1].eom = 1'b1;
            line_len = 0;
            word_len = 0;
            seen_text = 1'b0;
            frame_count = 0;
        end
    endfunction

    task automatic report(input string msg);
        if (err_cnt < MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    // input side
    logic in_acc = 1'b0;
    int   gap_cnt = 0;

    always @(posedge i_clk) begin
        in_acc <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            wrap_step(i_in_char, i_has_char, i_message_end);
        end
    end

    always @(negedge i_clk) begin
        t_text_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_cnt <= 0;
        end else if (!i_in_valid || in_acc) begin
            if (text_q.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (gap_cnt < text_q[0].gap) begin
                i_in_valid <= 1'b0;
                gap_cnt <= gap_cnt + 1;
            end else begin
                nxt = text_q.pop_front();
                i_in_char <= nxt.ch;
                i_has_char <= nxt.has;
                i_message_end <= nxt.fin;
                i_in_valid <= 1'b1;
                gap_cnt <= 0;
            end
        end
    end

    // output side
    logic out_acc = 1'b0;
    int   stall_left = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;

    always @(negedge i_clk) begin
        int pause;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end else if (out_acc) begin
            pause = calm ? 0 : $urandom_range(0, 5);
            i_out_ready <= (pause == 0);
            stall_left <= pause;
        end else if (stall_left != 0) begin
            i_out_ready <= (stall_left == 1);
            stall_left <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_frame_beat want;
        out_acc <= i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_frame_beats.size() == 0) begin
                report($sformatf("transfer %0d: char %02h with nothing pending",
                                 beat_cnt, o_frame_char));
            end else begin
                want = exp_frame_beats.pop_front();
                if (o_frame_char !== want.ch)
                    report($sformatf("transfer %0d: frame_char %02h, expected %02h",
                                     beat_cnt, o_frame_char, want.ch));
                if (o_end_of_frame !== want.eof)
                    report($sformatf("transfer %0d: end_of_frame %b, expected %b",
                                     beat_cnt, o_end_of_frame, want.eof));
                if (o_end_of_message !== want.eom)
                    report($sformatf("transfer %0d: end_of_message %b, expected %b",
                                     beat_cnt, o_end_of_message, want.eom));
            end
            beat_cnt++;
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    task automatic push_item(input logic [7:0] ch, input logic has, input logic fin);
        t_text_item it;
        it.ch = ch;
        it.has = has;
        it.fin = fin;
        it.gap = calm ? 0 : $urandom_range(0, 5);
        text_q.insert(text_q.size(), it);
        if (has || fin) stim_cnt++;
    endtask

    function automatic logic [7:0] rand_word_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0) return 8'($urandom_range(8'h61, 8'h7a));
        c = 8'($urandom_range(0, 255));
        while (is_blank(c)) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 3))
            0: return CHAR_SPACE;
            1: return CHAR_TAB;
            2: return CHAR_LF;
            default: return CHAR_CR;
        endcase
    endfunction

    task automatic gen_message();
        int n_words;
        int len;
        int w_eff;
        w_eff = eff_width();
        if ($urandom_range(0, 3) == 0) push_item(rand_blank(), 1'b1, 1'b0);
        n_words = $urandom_range(0, 5);
        for (int k = 0; k < n_words; k++) begin
            if (k > 0) repeat ($urandom_range(1, 3)) push_item(rand_blank(), 1'b1, 1'b0);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20)
                                              : $urandom_range(1, w_eff + 2);
            repeat (len) push_item(rand_word_char(), 1'b1, 1'b0);
            if ($urandom_range(0, 5) == 0) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
        if ($urandom_range(0, 3) == 0) push_item(rand_blank(), 1'b1, 1'b0);
        case ($urandom_range(0, 2))
            0: push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            1: push_item(rand_word_char(), 1'b1, 1'b1);
            default: push_item(rand_blank(), 1'b1, 1'b1);
        endcase
    endtask

    task automatic write_width(input logic [CFG_W-1:0] val);
        logic [APB_DW-1:0] data;
        data = $urandom();
        data[CFG_W-1:0] = val;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_FRAME_WIDTH;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        frame_width_q = val;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic settle();
        while (text_q.size() != 0 || i_in_valid || exp_frame_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [CFG_W-1:0] widths [N_PHASES];
        int quota;
        int goal;
        widths = '{5'd1, 5'd16, 5'd31, 5'd5, 5'd2, 5'd0, 5'd9, 5'd13, 5'd3};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty message, ignored item, blanks around odd bytes
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'hff, 1'b0, 1'b0);
        push_item(CHAR_SPACE, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hff, 1'b1, 1'b0);
        push_item(CHAR_TAB, 1'b1, 1'b0);
        push_item(CHAR_CR, 1'b1, 1'b0);
        push_item(CHAR_LF, 1'b1, 1'b0);
        push_item("q", 1'b1, 1'b0);
        push_item(CHAR_SPACE, 1'b1, 1'b1);
        // leave a line and a word open across the width change
        push_item("a", 1'b1, 1'b0);
        push_item("b", 1'b1, 1'b0);
        push_item(CHAR_SPACE, 1'b1, 1'b0);
        push_item("c", 1'b1, 1'b0);
        push_item("d", 1'b1, 1'b0);
        push_item("e", 1'b1, 1'b0);
        settle();
        write_width(5'd0);
        push_item("x", 1'b1, 1'b0);
        push_item("y", 1'b1, 1'b0);
        push_item(8'h5a, 1'b0, 1'b1);
        push_item(CHAR_LF, 1'b1, 1'b1);
        settle();
        write_width(5'd31);
        push_item("W", 1'b1, 1'b1);
        settle();

        // running item budget so one phase's overshoot shortens the next
        quota = (RANDOM_ITEMS - LONG_RUN - 1 - stim_cnt) / N_PHASES;
        goal = stim_cnt + LONG_RUN + 1;

        for (int p = 0; p < N_PHASES; p++) begin
            write_width(widths[p]);
            calm = (p == 3) || (p == 7);
            if (p == 1) hold_req = 1'b1;
            if (p == 0) begin
                // runs past the frame limit
                repeat (LONG_RUN) push_item(rand_word_char(), 1'b1, 1'b0);
                push_item(8'h00, 1'b0, 1'b1);
            end
            goal += quota;
            do gen_message(); while (stim_cnt < goal);
            if ($urandom_range(0, 1) == 1)
                repeat ($urandom_range(1, 6)) push_item(rand_word_char(), 1'b1, 1'b0);
            settle();
        end

        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
